// File: hdl/sktc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sktc_pkg
// Operation codes, status codes and field widths of the sorted key/count table.
// ----------------------------------------------------------------------------
package sktc_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 31;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAT_W-1:0]  status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_SEARCH = 2'd1;
  localparam kind_t KIND_UPDATE = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_MISS = 2'd3;

  localparam count_t COUNT_MAX = 32'h7FFF_FFFF;
  localparam count_t COUNT_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

// File: hdl/sorted_key_count_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_count_table_unit
// Table of key/count entries kept in ascending key order, with insert,
// search and saturating update, run by a small sequencer over one memory.
// ----------------------------------------------------------------------------
//  channel  ports                                        transfer
//  input    start, busy, in_kind, in_part_key, in_amount start && !busy
//  result   out_valid, out_status, out_count_value,      out_valid, one cycle
//           out_slot_index
//
//  An operation keeps busy high through a scan of one memory read per cycle
//  up to the key or the insert position, a decision step, then for an insert
//  one shift move per larger entry and a final write. The result shows in the
//  first cycle that busy is low again. The single read and write port of the
//  entry memory makes these steps run one after another. Reset empties the
//  table at once; the receiver cannot stall, and each result is shown for one
//  cycle.
// ----------------------------------------------------------------------------
module sorted_key_count_table_unit
  import sktc_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [KEY_W-1:0]    in_part_key,
  input  wire logic [COUNT_W-1:0]  in_amount,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [COUNT_W-1:0]       out_count_value,
  output logic [SLOT_W-1:0]        out_slot_index
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int TOT_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;

  key_t   key_mem [CAPACITY];
  count_t cnt_mem [CAPACITY];

  logic [2:0]       state_r, state_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r, kind_nxt;
  key_t             key_r, key_nxt;
  count_t           amt_r, amt_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [TOT_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] sh_r, sh_nxt;
  status_t          status_r, status_nxt;
  count_t           count_r, count_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;

  key_t             rkey_r;
  count_t           rcnt_r;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             key_we, cnt_we;
  key_t             wkey;
  count_t           wcnt;

  logic [COUNT_W:0]  sum;
  count_t            sat;
  logic [WIDE_W-1:0] slot_wide;

  always_comb begin
    sum = {rcnt_r[COUNT_W-1], rcnt_r} + {amt_r[COUNT_W-1], amt_r};
    if (sum[COUNT_W] != sum[COUNT_W-1]) begin
      sat = sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
    end else begin
      sat = sum[COUNT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    raddr         = idx_r;
    waddr         = idx_r;
    key_we        = 1'b0;
    cnt_we        = 1'b0;
    wkey          = key_r;
    wcnt          = amt_r;

    unique case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = in_part_key;
          amt_nxt   = in_amount;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          pos_nxt   = total_r;
          state_nxt = (total_r == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        raddr = idx_r + 1'b1;
        if (rkey_r == key_r) begin
          raddr     = idx_r;
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (rkey_r > key_r) begin
          pos_nxt   = TOT_W'(idx_r);
          state_nxt = S_DECIDE;
        end else if (TOT_W'(idx_r) + 1'b1 == total_r) begin
          pos_nxt   = total_r;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DECIDE: begin
        status_nxt = ST_MISS;
        count_nxt  = '0;
        slot_nxt   = '0;
        state_nxt  = S_IDLE;
        unique case (kind_r)
          KIND_INSERT: begin
            if (found_r) begin
              status_nxt    = ST_DUP;
              out_valid_nxt = 1'b1;
            end else if (total_r >= TOT_W'(CAPACITY)) begin
              status_nxt    = ST_FULL;
              out_valid_nxt = 1'b1;
            end else if (pos_r == total_r) begin
              state_nxt = S_PLACE;
            end else begin
              raddr     = IDX_W'(total_r - 1'b1);
              sh_nxt    = total_r[IDX_W-1:0];
              state_nxt = S_SHIFT;
            end
          end
          KIND_SEARCH: begin
            out_valid_nxt = 1'b1;
            if (found_r) begin
              status_nxt = ST_OK;
              count_nxt  = rcnt_r;
              slot_nxt   = idx_r;
            end
          end
          KIND_UPDATE: begin
            out_valid_nxt = 1'b1;
            if (found_r) begin
              cnt_we     = 1'b1;
              waddr      = idx_r;
              wcnt       = sat;
              status_nxt = ST_OK;
              count_nxt  = sat;
              slot_nxt   = idx_r;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        key_we = 1'b1;
        cnt_we = 1'b1;
        waddr  = sh_r;
        wkey   = rkey_r;
        wcnt   = rcnt_r;
        raddr  = sh_r - IDX_W'(2);
        sh_nxt = sh_r - 1'b1;
        if (TOT_W'(sh_r) - 1'b1 == pos_r) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        key_we        = 1'b1;
        cnt_we        = 1'b1;
        waddr         = pos_r[IDX_W-1:0];
        total_nxt     = total_r + 1'b1;
        status_nxt    = ST_OK;
        count_nxt     = amt_r;
        slot_nxt      = pos_r[IDX_W-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (cnt_we) begin
      cnt_mem[waddr] <= wcnt;
    end
    rkey_r <= key_mem[raddr];
    rcnt_r <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    amt_r    <= amt_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    sh_r     <= sh_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
    slot_r   <= slot_nxt;
  end

  assign slot_wide       = WIDE_W'(slot_r);
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_count_value = count_r;
  assign out_slot_index  = slot_wide[SLOT_W-1:0];

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted key/count table against a predictor of its own. A queue
// of pending operations is played into the command port with random gaps.
// Every result is compared with the oldest prediction. Directed operations
// hit the empty, front, middle and end insert cases, duplicates, saturation
// and the unused kind. Random operations then fill the table to capacity and
// keep working on present and absent keys.
// ----------------------------------------------------------------------------
module testbench;
  import sktc_pkg::*;

  localparam int          TABLE_DEPTH   = 16;
  localparam int          RANDOM_OPS    = 750;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          REPORT_LIMIT  = 10;
  localparam kind_t       KIND_UNUSED   = 2'd3;

  typedef struct {
    kind_t  kind;
    key_t   key;
    count_t amount;
  } table_op_t;

  typedef struct packed {
    status_t             status;
    count_t              count;
    logic [SLOT_W-1:0]   slot;
  } table_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [KEY_W-1:0]    in_part_key = '0;
  logic [COUNT_W-1:0]  in_amount = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [COUNT_W-1:0]  out_count_value;
  logic [SLOT_W-1:0]   out_slot_index;

  table_op_t     pending_ops[$];
  table_reply_t  expected_replies[$];
  key_t          tried_keys[$];

  key_t          shadow_keys[TABLE_DEPTH];
  count_t        shadow_counts[TABLE_DEPTH];
  int            shadow_total = 0;

  int            error_count = 0;
  int            cycle_count = 0;
  int            gap_left = 0;
  bit            handed_over = 1'b0;

  sorted_key_count_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_part_key(in_part_key),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_count_value(out_count_value),
    .out_slot_index(out_slot_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic table_reply_t predict_table_op(kind_t kind, key_t key, count_t amt);
    table_reply_t reply;
    bit           found;
    int           hit;
    int           pos;
    longint       sum;
    reply = '{status: ST_MISS, count: '0, slot: '0};
    found = 1'b0;
    hit = 0;
    for (int i = 0; i < shadow_total; i++) begin
      if (!found && shadow_keys[i] == key) begin
        found = 1'b1;
        hit = i;
      end
    end
    case (kind)
      KIND_INSERT: begin
        if (found) begin
          reply.status = ST_DUP;
        end else if (shadow_total >= TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_total && shadow_keys[pos] < key) pos++;
          for (int j = shadow_total; j > pos; j--) begin
            shadow_keys[j] = shadow_keys[j-1];
            shadow_counts[j] = shadow_counts[j-1];
          end
          shadow_keys[pos] = key;
          shadow_counts[pos] = amt;
          shadow_total++;
          reply = '{status: ST_OK, count: amt, slot: pos[SLOT_W-1:0]};
        end
      end
      KIND_SEARCH: begin
        if (found)
          reply = '{status: ST_OK, count: shadow_counts[hit], slot: hit[SLOT_W-1:0]};
      end
      KIND_UPDATE: begin
        if (found) begin
          sum = longint'(signed'(shadow_counts[hit])) + longint'(signed'(amt));
          if (sum > longint'(signed'(COUNT_MAX))) sum = longint'(signed'(COUNT_MAX));
          if (sum < longint'(signed'(COUNT_MIN))) sum = longint'(signed'(COUNT_MIN));
          shadow_counts[hit] = sum[COUNT_W-1:0];
          reply = '{status: ST_OK, count: shadow_counts[hit], slot: hit[SLOT_W-1:0]};
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (tried_keys.size() > 0 && r < 65)
      return tried_keys[$urandom_range(0, tried_keys.size() - 1)];
    if (r < 68) return '0;
    if (r < 71) return '1;
    return key_t'($urandom);
  endfunction

  function automatic count_t pick_amount();
    case ($urandom_range(0, 5))
      0: return COUNT_MAX;
      1: return COUNT_MIN;
      2: return count_t'($urandom_range(0, 16)) - count_t'(8);
      default: return count_t'($urandom);
    endcase
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return KIND_INSERT;
    if (r < 60) return KIND_SEARCH;
    if (r < 95) return KIND_UPDATE;
    return KIND_UNUSED;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_op(kind_t kind, key_t key, count_t amt);
    pending_ops.push_back('{kind: kind, key: key, amount: amt});
    if (kind == KIND_INSERT) tried_keys.push_back(key);
  endtask

  // driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    logic      next_start;
    table_op_t op;
    next_start = start;
    if (handed_over) begin
      handed_over = 1'b0;
      next_start = 1'b0;
      gap_left = pick_gap();
    end
    if (rst_n && !next_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_kind <= op.kind;
        in_part_key <= op.key;
        in_amount <= op.amount;
        next_start = 1'b1;
      end
    end
    start <= next_start;
  end

  // accept: predict each transaction taken by the block
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_replies.push_back(predict_table_op(in_kind, in_part_key, in_amount));
      handed_over = 1'b1;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    if (rst_n && out_valid) begin
      got = '{status: out_status, count: out_count_value, slot: out_slot_index};
      if (expected_replies.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d count %0d slot %0d",
                   got.status, $signed(got.count), got.slot);
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch: expected status %0d count %0d slot %0d, ",
                      "got status %0d count %0d slot %0d"},
                     want.status, $signed(want.count), want.slot,
                     got.status, $signed(got.count), got.slot);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    queue_op(KIND_SEARCH, key_t'(5), count_t'(0));
    queue_op(KIND_UPDATE, key_t'(5), count_t'(3));
    queue_op(KIND_UNUSED, key_t'(5), count_t'(1));
    queue_op(KIND_INSERT, key_t'(1000), count_t'(7));
    queue_op(KIND_INSERT, '0, COUNT_MIN);
    queue_op(KIND_INSERT, '1, COUNT_MAX);
    queue_op(KIND_INSERT, key_t'(500), '1);
    queue_op(KIND_INSERT, key_t'(1000), count_t'(9));
    queue_op(KIND_UPDATE, '1, count_t'(1));
    queue_op(KIND_UPDATE, '0, '1);
    queue_op(KIND_UPDATE, key_t'(500), count_t'(5));
    queue_op(KIND_UPDATE, '1, COUNT_MIN);
    queue_op(KIND_UPDATE, key_t'(1000), COUNT_MAX);
    queue_op(KIND_UPDATE, key_t'(1000), COUNT_MAX);
    queue_op(KIND_SEARCH, key_t'(1000), COUNT_MAX);
    queue_op(KIND_SEARCH, '0, count_t'(0));
    queue_op(KIND_SEARCH, '1, count_t'(0));
    queue_op(KIND_SEARCH, key_t'(501), count_t'(0));
    queue_op(KIND_UNUSED, key_t'(1000), '1);
    queue_op(KIND_INSERT, key_t'(999), count_t'(0));
    queue_op(KIND_INSERT, key_t'(1001), count_t'(-2));
    for (int i = 0; i < RANDOM_OPS; i++) queue_op(pick_kind(), pick_key(), pick_amount());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || start || expected_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() > 0) error_count++;
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
